@@ design/meb_pkg.sv @@
// Package for the breadcrumb maze explorer: widths, direction codes, reset values.
// No dependencies.
`default_nettype none
package meb_pkg;
  localparam int unsigned TileCapacity = 256;
  localparam logic [15:0] NoWallReset = 16'd100;
  localparam logic [15:0] MaxStepsReset = 16'hFFFF;

  typedef enum logic [2:0] {
    DIR_UP    = 3'd0,
    DIR_LEFT  = 3'd1,
    DIR_DOWN  = 3'd2,
    DIR_RIGHT = 3'd3,
    DIR_NONE  = 3'd4
  } dir_t;

  localparam logic CFG_NO_WALL   = 1'b0;
  localparam logic CFG_MAX_STEPS = 1'b1;

  // Neighbour coordinates one step away in direction d
  function automatic logic [7:0] step_x(input logic [7:0] x, input logic [1:0] d);
    step_x = (d == 2'd1) ? x - 8'd1 : (d == 2'd3) ? x + 8'd1 : x;
  endfunction

  function automatic logic [7:0] step_y(input logic [7:0] y, input logic [1:0] d);
    step_y = (d == 2'd0) ? y + 8'd1 : (d == 2'd2) ? y - 8'd1 : y;
  endfunction
endpackage
`default_nettype wire

@@ design/meb_search.sv @@
// Shared coordinate search unit: walks the tile table one entry a cycle.
// Depends on meb_pkg. Table read port is provided by the caller.
`default_nettype none
module meb_search #(
  parameter int unsigned IDX_W = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             go,
  input  wire logic [7:0]       key_x,
  input  wire logic [7:0]       key_y,
  input  wire logic [IDX_W:0]   count,
  output logic [IDX_W-1:0]      rd_addr,
  input  wire logic [15:0]      rd_xy,
  output logic                  done,
  output logic                  found,
  output logic [IDX_W-1:0]      hit_idx
);
  import meb_pkg::*;

  logic [IDX_W:0] idx_r, idx_nxt;
  logic           run_r, run_nxt, chk_r, chk_nxt;
  logic [IDX_W-1:0] cidx_r, cidx_nxt;

  assign rd_addr = idx_r[IDX_W-1:0];

  // Compare the registered read of the entry issued last cycle
  always_comb begin
    idx_nxt = idx_r;
    run_nxt = run_r;
    chk_nxt = 1'b0;
    cidx_nxt = idx_r[IDX_W-1:0];
    done = 1'b0;
    found = 1'b0;
    hit_idx = cidx_r;
    if (go) begin
      idx_nxt = '0;
      run_nxt = 1'b1;
    end else if (run_r) begin
      if (chk_r && rd_xy == {key_x, key_y}) begin
        done = 1'b1;
        found = 1'b1;
        run_nxt = 1'b0;
      end else if (idx_r >= count) begin
        if (!chk_r) begin
          done = 1'b1;
          run_nxt = 1'b0;
        end
      end else begin
        chk_nxt = 1'b1;
        idx_nxt = idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r <= 1'b0;
      chk_r <= 1'b0;
      idx_r <= '0;
    end else begin
      run_r <= run_nxt;
      chk_r <= run_nxt & chk_nxt;
      idx_r <= idx_nxt;
    end
    cidx_r <= cidx_nxt;
  end
endmodule
`default_nettype wire

@@ design/maze_explorer_breadcrumb_top.sv @@
// Top level of the breadcrumb maze explorer: sequencer, tile table, config.
// Depends on meb_pkg and meb_search.
//
// Usage: drive the eight distance readings and pulse in_start while in_busy is
// low; the request is taken at that edge and in_busy rises. The block maps the
// tile, then tries each direction in the order up, left, down, right with a
// linear coordinate search over the tile table, falls back to the breadcrumb,
// and finally searches for the target tile to enter or append it. Each search
// runs through one shared compare unit. The result is shown for one cycle with
// out_valid high; in_busy is already low in that cycle, so the next request
// can be taken there. The receiver cannot stall. Configuration writes on cfg_*
// are always accepted (cfg_ready tied high) and are meant for idle periods.
// Reset starts a fresh run at tile (0,0) heading up, registers at defaults.
// No clearing pass is needed: the table is only read below the fill count.
`default_nettype none
module maze_explorer_breadcrumb_top #(
  parameter int unsigned TILE_CAPACITY = meb_pkg::TileCapacity
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_start,
  output logic             in_busy,
  input  wire logic [15:0] in_dist_up_a,
  input  wire logic [15:0] in_dist_up_b,
  input  wire logic [15:0] in_dist_left_a,
  input  wire logic [15:0] in_dist_left_b,
  input  wire logic [15:0] in_dist_down_a,
  input  wire logic [15:0] in_dist_down_b,
  input  wire logic [15:0] in_dist_right_a,
  input  wire logic [15:0] in_dist_right_b,
  output logic             out_valid,
  output logic [2:0]       out_move_dir,
  output logic             out_going_back,
  output logic             out_run_done,
  output logic             out_table_full,
  output logic signed [7:0] out_next_x,
  output logic signed [7:0] out_next_y,
  output logic             out_next_is_new,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [15:0] cfg_data
);
  import meb_pkg::*;

  localparam int unsigned IDX_W = (TILE_CAPACITY > 2) ? $clog2(TILE_CAPACITY) : 1;
  localparam logic [IDX_W:0] CAP = (IDX_W+1)'(TILE_CAPACITY);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_LOAD2, S_DIR, S_DIRW, S_DEC, S_TGT, S_TGTW, S_OUT
  } state_t;

  state_t state_r;
  logic [15:0] nowall_r, maxst_r, steps_r;
  logic [IDX_W:0] count_r;
  logic [IDX_W-1:0] cur_r;
  logic over_r;
  logic [1:0] dir_r;
  logic [3:0] walls_r;
  logic [7:0] cx_r, cy_r, tx_r, ty_r;
  logic [2:0] back_r, move_r;
  logic mapped_r, goback_r, full_r, new_r;
  logic [127:0] din_r;

  // Tile table: coordinates, walls, mapped flag, breadcrumb
  logic [15:0] mem_xy [TILE_CAPACITY];
  logic [7:0]  mem_info [TILE_CAPACITY];
  logic [15:0] rd_xy_r;
  logic [7:0]  rd_info_r;
  logic        wr_en;
  logic [IDX_W-1:0] wr_addr, rd_addr, s_addr;
  logic [15:0] wr_xy;
  logic [7:0]  wr_info;
  logic        wr_xy_en;

  logic s_go, s_done, s_found;
  logic [IDX_W-1:0] s_hit;

  meb_search #(.IDX_W(IDX_W)) u_search (
    .clk(clk), .rst_n(rst_n), .go(s_go), .key_x(tx_r), .key_y(ty_r),
    .count(count_r), .rd_addr(s_addr), .rd_xy(rd_xy_r),
    .done(s_done), .found(s_found), .hit_idx(s_hit)
  );

  assign rd_addr = (state_r == S_LOAD) ? cur_r : s_addr;

  always_ff @(posedge clk) begin
    if (wr_en) mem_info[wr_addr] <= wr_info;
    if (wr_xy_en) mem_xy[wr_addr] <= wr_xy;
    rd_xy_r <= mem_xy[rd_addr];
    rd_info_r <= mem_info[rd_addr];
  end

  // Wall from readings
  logic [3:0] new_walls;
  always_comb begin
    for (int d = 0; d < 4; d++) begin
      new_walls[d] = (din_r[32*d +: 16] < nowall_r) && (din_r[32*d+16 +: 16] < nowall_r);
    end
  end

  // Record of the current tile; entry 0 has none stored before its first stop
  logic       ld_new;
  logic [3:0] ld_walls;
  logic [2:0] ld_back;
  assign ld_new = !mapped_r || !rd_info_r[4];
  assign ld_walls = ld_new ? new_walls : rd_info_r[3:0];
  assign ld_back = mapped_r ? rd_info_r[7:5] : DIR_NONE;

  assign cfg_ready = 1'b1;
  assign in_busy = (state_r != S_IDLE);
  logic [7:0] tgt_x, tgt_y;
  assign tgt_x = step_x(cx_r, move_r[1:0]);
  assign tgt_y = step_y(cy_r, move_r[1:0]);

  always_comb begin
    s_go = 1'b0;
    wr_en = 1'b0;
    wr_xy_en = 1'b0;
    wr_addr = cur_r;
    wr_xy = {cx_r, cy_r};
    wr_info = {ld_back, 1'b1, ld_walls};
    if (state_r == S_DIR && !walls_r[dir_r]) s_go = 1'b1;
    if (state_r == S_TGT) s_go = 1'b1;
    if (state_r == S_LOAD2 && ld_new) wr_en = 1'b1;
    if (state_r == S_LOAD2 && !mapped_r) wr_xy_en = 1'b1;
    if (state_r == S_TGTW && s_done && !s_found && count_r < CAP) begin
      wr_en = 1'b1;
      wr_xy_en = 1'b1;
      wr_addr = count_r[IDX_W-1:0];
      wr_xy = {tx_r, ty_r};
      wr_info = {1'b0, move_r[1:0] + 2'd2, 1'b0, 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      nowall_r <= NoWallReset;
      maxst_r <= MaxStepsReset;
      steps_r <= '0;
      count_r <= (IDX_W+1)'(1);
      cur_r <= '0;
      over_r <= 1'b0;
      out_valid <= 1'b0;
      mapped_r <= 1'b0;
      back_r <= DIR_NONE;
      cx_r <= '0;
      cy_r <= '0;
    end else begin
      out_valid <= 1'b0;
      if (cfg_valid) begin
        if (cfg_index == CFG_NO_WALL) nowall_r <= cfg_data;
        else maxst_r <= cfg_data;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_start) begin
            din_r <= {in_dist_right_b, in_dist_right_a, in_dist_down_b, in_dist_down_a,
                      in_dist_left_b, in_dist_left_a, in_dist_up_b, in_dist_up_a};
            move_r <= DIR_NONE;
            goback_r <= 1'b0;
            full_r <= 1'b0;
            new_r <= 1'b0;
            state_r <= over_r ? S_OUT : S_LOAD;
          end
        end
        S_LOAD: state_r <= S_LOAD2;
        S_LOAD2: begin
          // Map the tile on its first stop, else keep its stored walls
          walls_r <= ld_walls;
          back_r <= ld_back;
          mapped_r <= 1'b1;
          dir_r <= 2'd0;
          state_r <= S_DIR;
        end
        S_DIR: begin
          tx_r <= step_x(cx_r, dir_r);
          ty_r <= step_y(cy_r, dir_r);
          if (!walls_r[dir_r]) state_r <= S_DIRW;
          else if (dir_r == 2'd3) state_r <= S_DEC;
          else dir_r <= dir_r + 2'd1;
        end
        S_DIRW: begin
          if (s_done) begin
            if (!s_found) begin
              move_r <= {1'b0, dir_r};
              state_r <= S_DEC;
            end else if (dir_r == 2'd3) state_r <= S_DEC;
            else begin
              dir_r <= dir_r + 2'd1;
              state_r <= S_DIR;
            end
          end
        end
        S_DEC: begin
          if (steps_r != 16'hFFFF) steps_r <= steps_r + 16'd1;
          if (steps_r >= maxst_r) begin
            over_r <= 1'b1;
            move_r <= DIR_NONE;
            goback_r <= 1'b0;
            state_r <= S_OUT;
          end else if (move_r == DIR_NONE) begin
            if (back_r[2]) begin
              over_r <= 1'b1;
              state_r <= S_OUT;
            end else begin
              move_r <= back_r;
              goback_r <= 1'b1;
              state_r <= S_TGT;
            end
          end else state_r <= S_TGT;
        end
        S_TGT: begin
          tx_r <= tgt_x;
          ty_r <= tgt_y;
          state_r <= S_TGTW;
        end
        S_TGTW: begin
          if (s_done) begin
            if (s_found) begin
              cur_r <= s_hit;
              cx_r <= tx_r;
              cy_r <= ty_r;
            end else if (count_r >= CAP) begin
              full_r <= 1'b1;
              over_r <= 1'b1;
              move_r <= DIR_NONE;
              goback_r <= 1'b0;
            end else begin
              cur_r <= count_r[IDX_W-1:0];
              count_r <= count_r + 1'b1;
              cx_r <= tx_r;
              cy_r <= ty_r;
              new_r <= 1'b1;
            end
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Entry 0 coordinates are written on first map so searches see (0,0)
  assign out_move_dir = move_r;
  assign out_going_back = goback_r;
  assign out_run_done = over_r;
  assign out_table_full = full_r;
  assign out_next_x = cx_r;
  assign out_next_y = cy_r;
  assign out_next_is_new = new_r;
endmodule
`default_nettype wire

@@ tb/sv/tb_maze_explorer_breadcrumb_top.sv @@
// Self-checking testbench for the breadcrumb maze explorer top level.
// Depends on meb_pkg and the design; a scoreboard class predicts every stop result.
`default_nettype none
module tb_maze_explorer_breadcrumb_top;
  import meb_pkg::*;

  typedef logic [15:0] reading_t [8];

  // Tile table, breadcrumbs and expected stop results for one exploration run
  class meb_scoreboard;
    logic [7:0] tile_x [256];
    logic [7:0] tile_y [256];
    logic [3:0] tile_wall [256];
    bit         tile_seen [256];
    dir_t       crumb [256];
    int unsigned fill, here, decisions;
    bit         over;
    logic [15:0] wall_thr, step_cap;
    logic [15:0] pending [$];
    int errors, n_checked, n_new, n_back, n_full, n_done;

    function new();
      fill = 1; here = 0; decisions = 0; over = 0;
      tile_x[0] = 0; tile_y[0] = 0; tile_seen[0] = 0; crumb[0] = DIR_NONE;
      wall_thr = NoWallReset; step_cap = MaxStepsReset;
      errors = 0; n_checked = 0; n_new = 0; n_back = 0; n_full = 0; n_done = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == CFG_NO_WALL) wall_thr = val;
      else step_cap = val;
    endfunction

    function void neighbour(int unsigned t, int d, output logic [7:0] x, output logic [7:0] y);
      x = tile_x[t]; y = tile_y[t];
      case (d)
        DIR_UP:    y = y + 8'd1;
        DIR_LEFT:  x = x - 8'd1;
        DIR_DOWN:  y = y - 8'd1;
        default:   x = x + 8'd1;
      endcase
    endfunction

    function int unsigned lookup(logic [7:0] x, logic [7:0] y);
      int unsigned hit;
      hit = fill;
      for (int i = fill - 1; i >= 0; i--)
        if (tile_x[i] == x && tile_y[i] == y) hit = i;
      return hit;
    endfunction

    // Decide one stop and queue its expected result as {dir,back,done,full,new}, then {x,y}
    function void note_request(reading_t r);
      dir_t mv;
      logic [3:0] w;
      logic [7:0] x, y;
      logic goback, full, is_new;
      int unsigned t;
      mv = DIR_NONE; goback = 0; full = 0; is_new = 0;
      if (!over) begin
        if (!tile_seen[here]) begin
          w = 0;
          for (int d = 0; d < 4; d++)
            if (r[2*d] < wall_thr && r[2*d+1] < wall_thr) w[d] = 1'b1;
          tile_wall[here] = w;
          tile_seen[here] = 1;
        end
        for (int d = 0; d < 4; d++) begin
          if (mv == DIR_NONE && !tile_wall[here][d]) begin
            neighbour(here, d, x, y);
            if (lookup(x, y) == fill) mv = dir_t'(d);
          end
        end
        if (mv == DIR_NONE) begin
          if (crumb[here] == DIR_NONE) over = 1;
          else begin
            mv = crumb[here]; goback = 1;
          end
        end
        if (decisions >= step_cap) begin
          over = 1; mv = DIR_NONE; goback = 0;
        end
        if (decisions < 65535) decisions++;
        if (mv != DIR_NONE) begin
          neighbour(here, mv, x, y);
          t = lookup(x, y);
          if (t < fill) here = t;
          else if (fill >= 256) begin
            full = 1; over = 1; mv = DIR_NONE; goback = 0;
          end else begin
            tile_x[t] = x; tile_y[t] = y; tile_seen[t] = 0;
            crumb[t] = dir_t'((mv + 2) & 3);
            fill++; here = t; is_new = 1;
          end
        end
      end
      n_new += is_new; n_back += goback; n_full += full;
      pending.push_back({2'b00, mv, goback, over, full, 7'b0, is_new});
      pending.push_back({tile_x[here], tile_y[here]});
    endfunction

    // Compare one result against the oldest expectation
    function void check_result(logic [2:0] dir, logic back, logic done, logic full,
                               logic [7:0] x, logic [7:0] y, logic is_new);
      logic [15:0] f, xy;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result dir=%0d x=%0d y=%0d", $time, dir, x, y);
        errors++;
        return;
      end
      f = pending.pop_front();
      xy = pending.pop_front();
      n_checked++;
      n_done += done;
      if (f[13:11] !== dir) begin
        $display("%0t: move_dir expected %0d got %0d", $time, f[13:11], dir); errors++;
      end
      if (f[10] !== back) begin
        $display("%0t: going_back expected %0d got %0d", $time, f[10], back); errors++;
      end
      if (f[9] !== done) begin
        $display("%0t: run_done expected %0d got %0d", $time, f[9], done); errors++;
      end
      if (f[8] !== full) begin
        $display("%0t: table_full expected %0d got %0d", $time, f[8], full); errors++;
      end
      if (xy[15:8] !== x) begin
        $display("%0t: next_x expected %0d got %0d", $time, xy[15:8], x); errors++;
      end
      if (xy[7:0] !== y) begin
        $display("%0t: next_y expected %0d got %0d", $time, xy[7:0], y); errors++;
      end
      if (f[0] !== is_new) begin
        $display("%0t: next_is_new expected %0d got %0d", $time, f[0], is_new); errors++;
      end
    endfunction
  endclass

  logic clk, rst_n, in_start, in_busy;
  logic [15:0] in_dist_up_a, in_dist_up_b, in_dist_left_a, in_dist_left_b;
  logic [15:0] in_dist_down_a, in_dist_down_b, in_dist_right_a, in_dist_right_b;
  logic out_valid, out_going_back, out_run_done, out_table_full, out_next_is_new;
  logic [2:0] out_move_dir;
  logic signed [7:0] out_next_x, out_next_y;
  logic cfg_valid, cfg_ready, cfg_index;
  logic [15:0] cfg_data;

  meb_scoreboard sb;
  bit calm;
  int n_sent;

  maze_explorer_breadcrumb_top i_dut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("[maze_explorer_breadcrumb_top] ERROR");
    $finish;
  end

  // Check every strobed result
  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_move_dir, out_going_back, out_run_done, out_table_full,
                      out_next_x, out_next_y, out_next_is_new);
  end

  // Issue one request and hold it until the block takes it
  task automatic send_request(reading_t r);
    in_start <= 1'b1;
    {in_dist_up_a, in_dist_up_b, in_dist_left_a, in_dist_left_b} <= {r[0], r[1], r[2], r[3]};
    {in_dist_down_a, in_dist_down_b, in_dist_right_a, in_dist_right_b} <=
      {r[4], r[5], r[6], r[7]};
    do @(posedge clk); while (in_busy);
    sb.note_request(r);
    n_sent++;
    if (!calm && $urandom_range(0, 4) == 0) begin
      in_start <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
  endtask

  // Drain all results, then write one register
  task automatic write_reg(logic idx, logic [15:0] val);
    in_start <= 1'b0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    cfg_valid <= 1'b0;
  endtask

  // Readings for one stop; each direction is walled with the given odds in percent
  function automatic reading_t make_stop(int wall_pct);
    reading_t r;
    logic [15:0] thr;
    thr = sb.wall_thr;
    for (int d = 0; d < 4; d++) begin
      r[2*d] = 16'($urandom); r[2*d+1] = 16'($urandom);
      if (thr != 0 && $urandom_range(0, 99) < wall_pct) begin
        r[2*d] = 16'($urandom_range(0, thr - 1));
        r[2*d+1] = 16'($urandom_range(0, thr - 1));
      end else if ($urandom_range(0, 1)) begin
        r[2*d] = 16'($urandom_range(thr, 16'hFFFF));
      end else begin
        r[2*d+1] = 16'($urandom_range(thr, 16'hFFFF));
      end
    end
    if ($urandom_range(0, 9) == 0)
      foreach (r[i]) r[i] = 16'($urandom);
    return r;
  endfunction

  initial begin
    reading_t r;
    int ending, wall_pct;
    sb = new();
    calm = 0; n_sent = 0;
    rst_n <= 1'b0; in_start <= 1'b0; cfg_valid <= 1'b0; cfg_index <= CFG_NO_WALL;
    cfg_data <= '0;
    {in_dist_up_a, in_dist_up_b, in_dist_left_a, in_dist_left_b} <= '0;
    {in_dist_down_a, in_dist_down_b, in_dist_right_a, in_dist_right_b} <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: open start tile, then extremes and the threshold boundary
    r = '{default: 16'hFFFF};     send_request(r);
    r = '{default: 16'h0000};     send_request(r);
    r = '{default: 16'd99};       send_request(r);
    r = '{default: 16'd100};      send_request(r);
    r = '{16'd99, 16'd100, 16'd100, 16'd99, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0};
    send_request(r);
    r = '{16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 16'd0, 16'd0};
    send_request(r);
    r = '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'hFFFF, 16'h5555};
    send_request(r);
    r = '{default: 16'hAAAA};     send_request(r);
    r = '{default: 16'h5555};     send_request(r);

    // Hold off until the block has answered everything
    in_start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);

    // Top threshold: a direction is open only on a full-scale reading
    write_reg(CFG_NO_WALL, 16'hFFFF);
    write_reg(CFG_MAX_STEPS, 16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      r = make_stop(40); send_request(r);
    end
    r = '{default: 16'hFFFE}; send_request(r);

    // Zero threshold: nothing is ever a wall
    write_reg(CFG_NO_WALL, 16'd0);
    for (int i = 0; i < 8; i++) begin
      r = make_stop(0); send_request(r);
    end

    // Bulk exploration, ending by table overflow, return to start or step limit
    ending = $urandom_range(0, 2);
    wall_pct = (ending == 1) ? 50 : 20;
    write_reg(CFG_NO_WALL, 16'($urandom_range(1, 4000)));
    for (int i = 0; i < 440; i++) begin
      if (ending == 2 && i == 250) begin
        if ($urandom_range(0, 1)) write_reg(CFG_MAX_STEPS, 16'd0);
        else write_reg(CFG_MAX_STEPS, 16'(sb.decisions + $urandom_range(1, 8)));
      end
      if (i == 380) calm = 1;
      r = make_stop(wall_pct);
      send_request(r);
    end

    in_start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (1400) @(posedge clk);

    $display("Sent %0d stops, checked %0d results: %0d new tiles, %0d moves back,",
             n_sent, sb.n_checked, sb.n_new, sb.n_back);
    $display("%0d tiles stored, %0d finished results, %0d table overflows",
             sb.fill, sb.n_done, sb.n_full);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("[maze_explorer_breadcrumb_top] OK");
    end else begin
      $display("[maze_explorer_breadcrumb_top] ERROR");
    end
    $finish;
  end
endmodule
`default_nettype wire
